// ===== design/mst_pkg.sv =====
// package for the multi-slot software timer: widths, codes, types
`default_nettype none
package mst_pkg;

    localparam int NUM_SLOTS_DEF = 8;

    localparam int MODE_W = 2;
    localparam int ID_W   = 16;
    localparam int MS_W   = 23;
    localparam int DIV_W  = 16;
    localparam int CNT_W  = 32;
    localparam int PROD_W = 33;
    localparam int STEP_W = $clog2(PROD_W);

    localparam logic [DIV_W-1:0]  TICK_DIV_RESET = 16'd383;
    localparam logic [PROD_W-1:0] MS_TO_US       = 33'd1000;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 2'd0,
        MODE_TICK = 2'd1,
        MODE_READ = 2'd2,
        MODE_RSVD = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DIV_WAIT,
        ST_TICK_RD,
        ST_TICK_WR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]  ident;
        logic [CNT_W-1:0] remaining;
        logic [CNT_W-1:0] reload;
        logic             single;
    } slot_entry_t;

    typedef struct packed {
        logic             start;
        logic [MS_W-1:0]  period_ms;
        logic [DIV_W-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] ticks;
    } div_stat_t;

endpackage
`default_nettype wire

// ===== design/mst_div.sv =====
// milliseconds to ticks: multiply by 1000, then restoring divide one bit per cycle
`default_nettype none
module mst_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mst_pkg::div_ctrl_t ctrl,
    output mst_pkg::div_stat_t     stat
);
    import mst_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  den_reg, den_next;
    logic [DIV_W:0]    trial;
    logic              qbit;

    assign trial = {rem_reg, num_reg[PROD_W-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(PROD_W - 1);
            num_next  = PROD_W'(ctrl.period_ms) * MS_TO_US;
            rem_next  = '0;
            den_next  = (ctrl.divisor == '0) ? DIV_W'(1) : ctrl.divisor;
        end else if (busy_reg) begin
            num_next = {num_reg[PROD_W-2:0], qbit};
            rem_next = qbit ? DIV_W'(trial - {1'b0, den_reg}) : trial[DIV_W-1:0];
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign stat.done  = done_reg;
    assign stat.ticks = num_reg[PROD_W-1] ? '1 : num_reg[CNT_W-1:0];

endmodule
`default_nettype wire

// ===== design/multi_slot_software_timer.sv =====
// multi-slot software timer: slot table, tick walker and add sequencer
//
//   channel   direction  handshake               payload
//   s_        in         s_valid / s_ready       s_mode s_timer_id s_period_ms s_one_shot
//   m_        out        m_valid / m_ready       m_accepted m_event_bits
//   cfg_      in         cfg_wr_en (no wait)     cfg_wr_data -> tick_divisor
//
// read and reserved modes go straight to the response; a tick walks every slot (one slot table
// read and one write back per slot); an add scans the table, then, when a slot is found, runs
// 33 steps of the shared divider, and when the table is full answers after the scan.
// one transfer is worked on at a time; a new one is taken while a result waits.
// synchronous active-low reset clears the used bits and events and loads the divisor reset value.
`default_nettype none
module multi_slot_software_timer #(
    parameter int NUM_SLOTS = mst_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [mst_pkg::MODE_W-1:0] s_mode,
    input  wire logic [mst_pkg::ID_W-1:0]   s_timer_id,
    input  wire logic [mst_pkg::MS_W-1:0]   s_period_ms,
    input  wire logic                      s_one_shot,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_accepted,
    output logic [mst_pkg::ID_W-1:0]        m_event_bits,
    input  wire logic                      cfg_wr_en,
    input  wire logic [mst_pkg::DIV_W-1:0]  cfg_wr_data
);
    import mst_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [ID_W-1:0]      pending_reg, pending_next;
    logic [DIV_W-1:0]     tick_div_reg;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_acc_reg, m_acc_next;
    logic [ID_W-1:0]      m_ev_reg, m_ev_next;

    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [MS_W-1:0]      ms_reg, ms_next;
    logic                 single_reg, single_next;
    logic                 hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic                 hit_single_reg, hit_single_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic                 resp_acc_reg, resp_acc_next;
    logic [ID_W-1:0]      resp_ev_reg, resp_ev_next;

    slot_entry_t          slot_mem [NUM_SLOTS];
    slot_entry_t          rd_data_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    slot_entry_t          mem_wdata;

    div_ctrl_t            div_ctrl;
    div_stat_t            div_stat;

    logic                 last_slot;
    logic                 hit_now;
    logic                 free_now;
    logic [CNT_W-1:0]     tick_dec;

    mst_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .stat    (div_stat)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_accepted   = m_acc_reg;
    assign m_event_bits = m_ev_reg;

    assign last_slot = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign hit_now   = used_reg[idx_reg] && (rd_data_reg.ident == id_reg) && !hit_found_reg;
    assign free_now  = !used_reg[idx_reg] && !free_found_reg;
    assign tick_dec  = rd_data_reg.remaining - CNT_W'(1);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        pending_next    = pending_reg;
        m_valid_next    = m_valid_reg;
        m_acc_next      = m_acc_reg;
        m_ev_next       = m_ev_reg;
        mode_next       = mode_reg;
        id_next         = id_reg;
        ms_next         = ms_reg;
        single_next     = single_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_single_next = hit_single_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        resp_acc_next   = resp_acc_reg;
        resp_ev_next    = resp_ev_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rd_data_reg;
        div_ctrl.start     = 1'b0;
        div_ctrl.period_ms = ms_reg;
        div_ctrl.divisor   = tick_div_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next       = s_mode;
                    id_next         = s_timer_id;
                    ms_next         = s_period_ms;
                    single_next     = s_one_shot;
                    idx_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    resp_acc_next   = 1'b1;
                    resp_ev_next    = '0;
                    case (mode_t'(s_mode))
                        MODE_ADD:  state_next = ST_SCAN_RD;
                        MODE_TICK: state_next = ST_TICK_RD;
                        MODE_READ: begin
                            resp_ev_next = pending_reg;
                            pending_next = '0;
                            state_next   = ST_RESP;
                        end
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (hit_now) begin
                    hit_found_next  = 1'b1;
                    hit_idx_next    = idx_reg;
                    hit_single_next = rd_data_reg.single;
                end
                if (free_now) begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (last_slot) begin
                    if (hit_found_next || free_found_next) begin
                        div_ctrl.start = 1'b1;
                        state_next     = ST_DIV_WAIT;
                    end else begin
                        resp_acc_next = 1'b0;
                        state_next    = ST_RESP;
                    end
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    mem_we              = 1'b1;
                    mem_waddr           = hit_found_reg ? hit_idx_reg : free_idx_reg;
                    mem_wdata.ident     = id_reg;
                    mem_wdata.remaining = div_stat.ticks;
                    mem_wdata.reload    = div_stat.ticks;
                    mem_wdata.single    = hit_found_reg ? hit_single_reg : single_reg;
                    used_next[mem_waddr] = 1'b1;
                    state_next          = ST_RESP;
                end
            end
            ST_TICK_RD: begin
                state_next = ST_TICK_WR;
            end
            ST_TICK_WR: begin
                if (used_reg[idx_reg] && (rd_data_reg.remaining != '0)) begin
                    mem_we = 1'b1;
                    if (tick_dec == '0) begin
                        pending_next        = pending_reg | rd_data_reg.ident;
                        mem_wdata.remaining = rd_data_reg.single ? '0 : rd_data_reg.reload;
                    end else begin
                        mem_wdata.remaining = tick_dec;
                    end
                end
                if (last_slot) begin
                    state_next = ST_RESP;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_TICK_RD;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_acc_next   = resp_acc_reg;
                    m_ev_next    = resp_ev_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            pending_reg  <= '0;
            tick_div_reg <= TICK_DIV_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                tick_div_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        m_acc_reg      <= m_acc_next;
        m_ev_reg       <= m_ev_next;
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        ms_reg         <= ms_next;
        single_reg     <= single_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_single_reg <= hit_single_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        resp_acc_reg   <= resp_acc_next;
        resp_ev_reg    <= resp_ev_next;
    end

    // slot table
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[idx_reg];
    end

    // read transfer leaves no pending events behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_mode == MODE_READ)) |=> (pending_reg == '0))
        else $error("events not cleared by read");

    // a slot once claimed stays claimed
    assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> ((used_reg & $past(used_reg)) == $past(used_reg)))
        else $error("slot used bit dropped");

    // table writes only from the add and tick write-back steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ((state_reg == ST_DIV_WAIT) || (state_reg == ST_TICK_WR)))
        else $error("slot table written outside write step");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider result with no add waiting");

endmodule
`default_nettype wire
